// ===== design/fqbp_pkg.sv =====
// Package for the float quantizer and bit packer: payload structs,
// register indexes and sizing constants. Depends on nothing.
`timescale 1ns / 1ps
package fqbp_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CODE_BITS = 2'd0;
  localparam logic [1:0] CFG_SCALE     = 2'd1;

  localparam logic [4:0]  CODE_BITS_RST = 5'd16;
  localparam logic [31:0] SCALE_RST     = 32'h3F80_0000;

  // Code queue between the quantizer and the packer.
  localparam int unsigned QDepth = 8;
  localparam int unsigned QAw    = $clog2(QDepth);

  // Result queue inside the packer; it must hold two words per item.
  localparam int unsigned ODepth = 4;
  localparam int unsigned OAw    = $clog2(ODepth);

  typedef struct packed {
    logic [31:0] sample_float;
    logic        is_final;
  } in_item_t;

  typedef struct packed {
    logic [63:0] packed_word;
    logic [6:0]  valid_bits;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic [30:0] code;
    logic        is_final;
  } code_item_t;

endpackage

// ===== design/fqbp_front.sv =====
// Quantizer pipeline: float multiply, round to single, round half away
// to an integer, sign and mask. Depends on fqbp_pkg.
`timescale 1ns / 1ps
module fqbp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  fqbp_pkg::in_item_t in_item_i,
  input  logic [4:0]         code_bits_i,
  input  logic [31:0]        scale_i,
  output logic               out_valid_o,
  output fqbp_pkg::code_item_t out_item_o
);
  import fqbp_pkg::*;

  // Stage 1: operand decode and mantissa product.
  logic        v1_q, ovf1_q, sgn1_q, fin1_q;
  logic [47:0] p1_q;
  logic [8:0]  es1_q;
  // Stage 2: leading one position.
  logic        v2_q, ovf2_q, sgn2_q, fin2_q, zero2_q;
  logic [47:0] p2_q;
  logic [8:0]  es2_q;
  logic [5:0]  l2_q;
  // Stage 3: normalize and round to 24 significant bits.
  logic        v3_q, ovf3_q, sgn3_q, fin3_q, zero3_q;
  logic [24:0] s3_q;
  logic [9:0]  t3_q;
  // Stage 4: integer rounding, sign, mask.
  logic        v4_q;
  code_item_t  o4_q;

  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic [7:0]  eea, eeb;
  logic        ovf1_d;
  logic [5:0]  l2_d;
  logic [47:0] n3;
  logic [24:0] s3_d;
  logic [9:0]  t3_d;
  logic [32:0] z4, y4;
  logic [33:0] m4;
  logic [30:0] sv4, mask4;
  logic [31:0] mask_w;
  logic [5:0]  r4;
  logic [30:0] code4_d;

  always_comb begin
    ea     = in_item_i.sample_float[30:23];
    eb     = scale_i[30:23];
    ma     = {ea != 8'd0, in_item_i.sample_float[22:0]};
    mb     = {eb != 8'd0, scale_i[22:0]};
    eea    = (ea == 8'd0) ? 8'd1 : ea;
    eeb    = (eb == 8'd0) ? 8'd1 : eb;
    // Any infinity or NaN operand ends in the overflow pattern.
    ovf1_d = (ea == 8'hFF) || (eb == 8'hFF);
  end

  always_comb begin
    l2_d = '0;
    for (int i = 0; i < 48; i++) begin
      if (p1_q[i]) l2_d = 6'(i);
    end
  end

  always_comb begin
    n3   = p2_q << (6'd47 - l2_q);
    // Round to nearest even on the significand.
    s3_d = {1'b0, n3[47:24]} +
           25'(n3[23] & ((|n3[22:0]) | n3[24]));
    // t is the value's exponent plus 300.
    t3_d = {1'b0, es2_q} + {4'b0, l2_q};
  end

  always_comb begin
    r4      = 6'(10'd330 - t3_q);
    z4      = {s3_q, 8'b0};
    y4      = z4 >> r4;
    m4      = ({1'b0, y4} + 34'd1) >> 1;
    mask_w  = (32'd1 << code_bits_i) - 32'd1;
    mask4   = mask_w[30:0];
    sv4     = sgn3_q ? (31'd0 - m4[30:0]) : m4[30:0];
    code4_d = sv4 & mask4;
    // Overflow gives 0x80000000, whose low 31 bits are zero.
    if (ovf3_q || (t3_q > 10'd330) || zero3_q || (t3_q < 10'd298) ||
        (m4[32:31] != 2'b00)) begin
      code4_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q    <= ma * mb;
    es1_q   <= {1'b0, eea} + {1'b0, eeb};
    ovf1_q  <= ovf1_d;
    sgn1_q  <= in_item_i.sample_float[31] ^ scale_i[31];
    fin1_q  <= in_item_i.is_final;

    p2_q    <= p1_q;
    es2_q   <= es1_q;
    l2_q    <= l2_d;
    zero2_q <= (p1_q == 48'd0);
    ovf2_q  <= ovf1_q;
    sgn2_q  <= sgn1_q;
    fin2_q  <= fin1_q;

    s3_q    <= s3_d;
    t3_q    <= t3_d;
    zero3_q <= zero2_q;
    ovf3_q  <= ovf2_q;
    sgn3_q  <= sgn2_q;
    fin3_q  <= fin2_q;

    o4_q.code     <= code4_d;
    o4_q.is_final <= fin3_q;
  end

  assign out_valid_o = v4_q;
  assign out_item_o  = o4_q;
endmodule

// ===== design/fqbp_code_fifo.sv =====
// Short queue of codes between the quantizer and the packer.
// Depends on fqbp_pkg.
`timescale 1ns / 1ps
module fqbp_code_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  fqbp_pkg::code_item_t wr_item_i,
  output logic                 rd_valid_o,
  output fqbp_pkg::code_item_t rd_item_o,
  input  logic                 rd_i
);
  import fqbp_pkg::*;

  code_item_t     mem_q [QDepth];
  logic [QAw-1:0] wp_q, rp_q;
  logic [QAw:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wr_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 1'b1;
      if (rd_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QAw+1)'(wr_i) - (QAw+1)'(rd_i);
    end
  end

  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rp_q];
endmodule

// ===== design/fqbp_packer.sv =====
// Bit packer: appends codes into a 64-bit accumulator and queues the
// finished and flushed words. Depends on fqbp_pkg.
`timescale 1ns / 1ps
module fqbp_packer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [4:0]           code_bits_i,
  input  logic                 code_valid_i,
  input  fqbp_pkg::code_item_t code_item_i,
  output logic                 code_pop_o,
  output logic                 empty,
  output fqbp_pkg::out_item_t  out_item_o,
  input  logic                 pop
);
  import fqbp_pkg::*;

  logic [63:0]    acc_q, acc_d;
  logic [5:0]     fill_q, fill_d;
  out_item_t      mem_q [ODepth];
  logic [OAw-1:0] wp_q, rp_q;
  logic [OAw:0]   cnt_q;

  logic [94:0] wide;
  logic [6:0]  sum;
  logic        take, deq, full_word, flush;
  out_item_t   w0, w1, wa, wb;
  logic [1:0]  nwr;

  // An item is taken only when two result slots are free.
  assign take = code_valid_i && (cnt_q <= (OAw+1)'(ODepth - 2));
  assign deq  = pop && !empty;

  always_comb begin
    wide      = {64'b0, code_item_i.code} << fill_q;
    sum       = {1'b0, fill_q} + {2'b0, code_bits_i};
    full_word = sum[6];
    w0.packed_word = acc_q | wide[63:0];
    w0.valid_bits  = 7'd64;
    w0.last_word   = code_item_i.is_final && (sum[5:0] == 6'd0);
    if (full_word) begin
      acc_d = {33'b0, wide[94:64]};
    end else begin
      acc_d = acc_q | wide[63:0];
    end
    fill_d = sum[5:0];
    flush  = code_item_i.is_final && (fill_d != 6'd0);
    w1.packed_word = acc_d;
    w1.valid_bits  = {1'b0, fill_d};
    w1.last_word   = 1'b1;
    wa  = full_word ? w0 : w1;
    wb  = w1;
    nwr = 2'(full_word) + 2'(flush);
  end

  always_ff @(posedge clk_i) begin
    if (take && (nwr != 2'd0)) mem_q[wp_q] <= wa;
    if (take && (nwr == 2'd2)) mem_q[wp_q + 1'b1] <= wb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      fill_q <= '0;
      wp_q   <= '0;
      rp_q   <= '0;
      cnt_q  <= '0;
    end else begin
      if (take) begin
        if (code_item_i.is_final) begin
          acc_q  <= '0;
          fill_q <= '0;
        end else begin
          acc_q  <= acc_d;
          fill_q <= fill_d;
        end
        wp_q <= wp_q + OAw'(nwr);
      end
      if (deq) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (take ? (OAw+1)'(nwr) : '0) - (OAw+1)'(deq);
    end
  end

  assign code_pop_o = take;
  assign empty      = (cnt_q == '0);
  assign out_item_o = mem_q[rp_q];
endmodule

// ===== design/float_quantize_bit_packer.sv =====
// Top level of the float quantizer and bit packer.
// Depends on fqbp_pkg, fqbp_front, fqbp_code_fifo and fqbp_packer.
//
// Input side is a queue: drive in_item_i and push; an item is taken
// on a clock edge with push high and full low. Each item is one IEEE
// single sample and a flag marking the last sample of a buffer.
// Result side is a queue: while empty is low the oldest 64-bit word is
// on out_item_o, and pop takes it. An item yields zero, one or two words.
// Configuration writes (code_bits, scale_float) use cfg_valid_i with
// cfg_ready_o, which is always high; write only while the block is idle.
// From push to the first word on the result side an item passes the
// four quantizer stages (multiply, leading one, round to single, round
// to integer), the code queue and the packer's word queue.
// One item per cycle is sustained while the receiver keeps popping
// words; that rate rests on the packer's accumulator update. The code
// queue holds eight items and full rises once eight items sit in the
// quantizer and queue together, so a stalled receiver backs up to full.
// Reset clears the accumulator, fill count and queues and restores
// code_bits to 16 and scale_float to 1.0.
`timescale 1ns / 1ps
module float_quantize_bit_packer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  fqbp_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output fqbp_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import fqbp_pkg::*;

  logic [4:0]     code_bits_q;
  logic [31:0]    scale_q;
  logic [QAw:0]   credit_q;
  logic           accept, q_wr, q_valid, q_pop;
  code_item_t     q_wr_item, q_rd_item;

  assign cfg_ready_o = 1'b1;
  assign full        = (credit_q == (QAw+1)'(QDepth));
  assign accept      = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_bits_q <= CODE_BITS_RST;
      scale_q     <= SCALE_RST;
      credit_q    <= '0;
    end else begin
      if (cfg_valid_i && (cfg_index_i == CFG_CODE_BITS)) code_bits_q <= cfg_data_i[4:0];
      if (cfg_valid_i && (cfg_index_i == CFG_SCALE))     scale_q     <= cfg_data_i;
      // Items in the quantizer plus items in the code queue.
      credit_q <= credit_q + (QAw+1)'(accept) - (QAw+1)'(q_pop);
    end
  end

  fqbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .in_item_i   (in_item_i),
    .code_bits_i (code_bits_q),
    .scale_i     (scale_q),
    .out_valid_o (q_wr),
    .out_item_o  (q_wr_item)
  );

  fqbp_code_fifo u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (q_wr),
    .wr_item_i  (q_wr_item),
    .rd_valid_o (q_valid),
    .rd_item_o  (q_rd_item),
    .rd_i       (q_pop)
  );

  fqbp_packer u_packer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .code_bits_i  (code_bits_q),
    .code_valid_i (q_valid),
    .code_item_i  (q_rd_item),
    .code_pop_o   (q_pop),
    .empty        (empty),
    .out_item_o   (out_item_o),
    .pop          (pop)
  );
endmodule
